>>> sv/urhp_pkg.sv
// Package for the USB root hub port: opcodes, feature selectors, status and change bits.
package urhp_pkg;

  typedef enum logic [2:0] {
    OP_TICK          = 3'd0,
    OP_GET_STATUS    = 3'd1,
    OP_SET_FEATURE   = 3'd2,
    OP_CLEAR_FEATURE = 3'd3,
    OP_CHANGE_POLL   = 3'd4,
    OP_HUB_STATUS    = 3'd5,
    OP_OTHER         = 3'd6
  } op_e;

  localparam logic [15:0] FEAT_ENABLE       = 16'd1;
  localparam logic [15:0] FEAT_RESET        = 16'd4;
  localparam logic [15:0] FEAT_POWER        = 16'd8;
  localparam logic [15:0] FEAT_C_CONNECTION = 16'd16;
  localparam logic [15:0] FEAT_C_RESET      = 16'd20;

  // bit positions in wPortStatus / wPortChange
  localparam int unsigned ST_CONNECTION = 0;
  localparam int unsigned ST_ENABLE     = 1;
  localparam int unsigned ST_RESET      = 4;
  localparam int unsigned ST_POWER      = 8;
  localparam int unsigned CH_CONNECTION = 0;
  localparam int unsigned CH_RESET      = 4;

  localparam logic [15:0] RESET_TICKS_DEFAULT = 16'd50;
  localparam logic [15:0] VALID_PORT          = 16'd1;
  localparam logic [7:0]  PORT1_CHANGE_MAP    = 8'd2;

  localparam int unsigned IN_WIDTH  = 40;
  localparam int unsigned OUT_WIDTH = 48;

  typedef struct packed {
    logic [15:0] status;
    logic [15:0] change;
  } port_state_t;

  typedef struct packed {
    logic        request_error;
    logic [7:0]  change_bitmap;
    logic [15:0] port_change;
    logic [15:0] status_word;
  } result_t;

endpackage

>>> sv/usb_root_hub_port_top.sv
// Top level of the USB 2.0 root hub port status block.
//
// One downstream port of a USB 2.0 root hub: keeps wPortStatus, wPortChange and the
// port-reset countdown, and answers one request or tick per input beat with exactly one
// result beat (status, change, hub change bitmap, stall flag). Every beat is decoded and
// applied to the port state in the cycle it is accepted, so the block takes one beat per
// clock while the skid register is empty; each result is registered. A two-entry output
// stage (output register plus skid register) lets input keep flowing for one beat while
// the master side stalls. reset_ticks (default 50) is written through cfg_we_i and
// cfg_wdata_i by the user only while the block is idle; the block does not enforce it.
module usb_root_hub_port_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] operation, [18:3] feature, [34:19] port_index, [35] device_present
  input  logic [urhp_pkg::IN_WIDTH-1:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] status_word, [31:16] port_change, [39:32] change_bitmap, [40] request_error
  output logic [urhp_pkg::OUT_WIDTH-1:0] m_axis_tdata_o
);
  import urhp_pkg::*;

  logic [15:0] reset_ticks_q;
  port_state_t state_q, state_d;
  logic [15:0] countdown_q, countdown_d;

  logic        out_valid_q, skid_valid_q;
  result_t     out_data_q, skid_data_q;
  result_t     res;
  logic        err;
  logic        in_fire, out_fire;

  logic [2:0]  op;
  logic [15:0] feat;
  logic [15:0] port;
  logic        present;

  assign op      = s_axis_tdata_i[2:0];
  assign feat    = s_axis_tdata_i[18:3];
  assign port    = s_axis_tdata_i[34:19];
  assign present = s_axis_tdata_i[35];

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;

  function automatic port_state_t link_update(port_state_t s, logic dev);
    port_state_t r;
    r = s;
    if (!s.status[ST_POWER]) begin
      r.status = '0;
      r.change = '0;
    end else if (!dev) begin
      r.status[ST_CONNECTION] = 1'b0;
      r.status[ST_ENABLE]     = 1'b0;
      if (s.status[ST_CONNECTION]) r.change[CH_CONNECTION] = 1'b1;
    end else begin
      r.status[ST_CONNECTION] = 1'b1;
      if (!s.status[ST_CONNECTION]) r.change[CH_CONNECTION] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    countdown_d = countdown_q;
    err         = 1'b0;
    unique case (op_e'(op))
      OP_TICK: begin
        if (countdown_q != 16'd0) countdown_d = countdown_q - 16'd1;
      end
      OP_GET_STATUS: begin
        err = (port != VALID_PORT);
        if (state_d.status[ST_RESET] && countdown_q == 16'd0) begin
          state_d.change[CH_RESET] = 1'b1;
          state_d.status[ST_RESET] = 1'b0;
        end
        state_d = link_update(state_d, present);
      end
      OP_SET_FEATURE: begin
        if (feat == FEAT_POWER) begin
          state_d.status[ST_POWER] = 1'b1;
          state_d = link_update(state_d, present);
        end else if (feat == FEAT_RESET) begin
          // reset request on an empty port is dropped silently
          if (state_q.status[ST_CONNECTION]) begin
            state_d.status[ST_RESET] = 1'b1;
            countdown_d = reset_ticks_q;
            state_d = link_update(state_d, present);
          end
        end else begin
          err = 1'b1;
        end
      end
      OP_CLEAR_FEATURE: begin
        unique case (feat)
          FEAT_ENABLE: state_d.status[ST_ENABLE] = 1'b0;
          FEAT_POWER: begin
            state_d.status[ST_POWER] = 1'b0;
            state_d = link_update(state_d, present);
          end
          FEAT_C_CONNECTION: begin
            state_d.change[CH_CONNECTION] = 1'b0;
            state_d = link_update(state_d, present);
          end
          FEAT_C_RESET: begin
            state_d.change[CH_RESET] = 1'b0;
            state_d = link_update(state_d, present);
          end
          default: err = 1'b1;
        endcase
      end
      OP_CHANGE_POLL, OP_HUB_STATUS: begin
      end
      default: err = 1'b1;
    endcase
  end

  always_comb begin
    res.status_word   = state_d.status;
    res.port_change   = state_d.change;
    res.change_bitmap = (|state_d.change[4:0]) ? PORT1_CHANGE_MAP : 8'd0;
    res.request_error = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_ticks_q <= RESET_TICKS_DEFAULT;
      state_q       <= '0;
      countdown_q   <= '0;
    end else begin
      if (cfg_we_i) reset_ticks_q <= cfg_wdata_i;
      if (in_fire) begin
        state_q     <= state_d;
        countdown_q <= countdown_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) out_data_q <= skid_data_q;
      else if (in_fire) out_data_q <= res;
    end else if (in_fire) begin
      skid_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");

  a_power_off_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.status != 16'd0) |-> state_q.status[ST_POWER])
    else $error("status bits set while port unpowered");

  a_bitmap_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.change_bitmap ==
                     ((|out_data_q.port_change[4:0]) ? PORT1_CHANGE_MAP : 8'd0)))
    else $error("change bitmap disagrees with port change word");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> ($stable(state_q) && $stable(countdown_q)))
    else $error("port state moved without an input beat");
`endif

endmodule

>>> tb/tb_usb_root_hub_port_top.sv
// Testbench for usb_root_hub_port_top: directed and random port requests checked against a port model.
`timescale 1ns / 1ps

module tb_usb_root_hub_port_top;
  import urhp_pkg::*;

  localparam logic [2:0] OP_RESERVED = 3'd7;  // encodable but undefined opcode
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_PER_PHASE = 125;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] feat;
    logic [15:0] port;
    logic        present;
  } port_req_t;

  typedef struct packed {
    port_req_t   req;
    logic        typed;
    logic [15:0] st;
    logic [15:0] ch;
    logic [7:0]  map;
    logic        err;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [47:0] m_axis_tdata_o;

  // port model state
  logic [15:0] mdl_status;
  logic [15:0] mdl_change;
  logic [15:0] mdl_countdown;
  logic [15:0] mdl_reset_ticks;

  result_t     pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  logic        link_up;

  dir_row_t    dir_tab[25];

  usb_root_hub_port_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void follow_link(input logic present);
    logic was_connected;
    was_connected = mdl_status[ST_CONNECTION];
    if (!mdl_status[ST_POWER]) begin
      mdl_status = '0;
      mdl_change = '0;
    end else if (!present) begin
      mdl_status[ST_CONNECTION] = 1'b0;
      mdl_status[ST_ENABLE] = 1'b0;
      if (was_connected) mdl_change[CH_CONNECTION] = 1'b1;
    end else begin
      mdl_status[ST_CONNECTION] = 1'b1;
      if (!was_connected) mdl_change[CH_CONNECTION] = 1'b1;
    end
  endfunction

  function automatic result_t port_step(input port_req_t r);
    result_t res;
    logic    err;
    err = 1'b0;
    case (r.op)
      OP_TICK: begin
        if (mdl_countdown != 16'd0) mdl_countdown = mdl_countdown - 16'd1;
      end
      OP_GET_STATUS: begin
        // bad port stalls but the read still completes a reset and updates the link
        err = (r.port != VALID_PORT);
        if (mdl_status[ST_RESET] && mdl_countdown == 16'd0) begin
          mdl_change[CH_RESET] = 1'b1;
          mdl_status[ST_RESET] = 1'b0;
        end
        follow_link(r.present);
      end
      OP_SET_FEATURE: begin
        case (r.feat)
          FEAT_POWER: begin
            mdl_status[ST_POWER] = 1'b1;
            follow_link(r.present);
          end
          FEAT_RESET: begin
            if (mdl_status[ST_CONNECTION]) begin
              mdl_status[ST_RESET] = 1'b1;
              mdl_countdown = mdl_reset_ticks;
              follow_link(r.present);
            end
          end
          default: err = 1'b1;
        endcase
      end
      OP_CLEAR_FEATURE: begin
        case (r.feat)
          FEAT_ENABLE: mdl_status[ST_ENABLE] = 1'b0;
          FEAT_POWER: begin
            mdl_status[ST_POWER] = 1'b0;
            follow_link(r.present);
          end
          FEAT_C_CONNECTION: begin
            mdl_change[CH_CONNECTION] = 1'b0;
            follow_link(r.present);
          end
          FEAT_C_RESET: begin
            mdl_change[CH_RESET] = 1'b0;
            follow_link(r.present);
          end
          default: err = 1'b1;
        endcase
      end
      OP_CHANGE_POLL, OP_HUB_STATUS: ;
      default: err = 1'b1;
    endcase
    res.status_word   = mdl_status;
    res.port_change   = mdl_change;
    res.change_bitmap = (mdl_change[4:0] != 5'd0) ? PORT1_CHANGE_MAP : 8'd0;
    res.request_error = err;
    return res;
  endfunction

  // mostly legal traffic on port 1 with a device that comes and goes
  function automatic port_req_t random_request();
    port_req_t   r;
    int unsigned pick;
    if ($urandom_range(0, 99) < 8) link_up = ~link_up;
    r.present = link_up;
    r.port    = ($urandom_range(0, 1) != 0) ? VALID_PORT : 16'($urandom_range(0, 65535));
    r.feat    = 16'($urandom_range(0, 65535));
    pick      = $urandom_range(0, 99);
    if (pick < 28) begin
      r.op = OP_TICK;
    end else if (pick < 48) begin
      r.op = OP_GET_STATUS;
      r.port = ($urandom_range(0, 99) < 85) ? VALID_PORT : 16'($urandom_range(0, 65535));
    end else if (pick < 66) begin
      r.op = OP_SET_FEATURE;
      pick = $urandom_range(0, 99);
      if (pick < 45) r.feat = FEAT_POWER;
      else if (pick < 90) r.feat = FEAT_RESET;
    end else if (pick < 80) begin
      r.op = OP_CLEAR_FEATURE;
      pick = $urandom_range(0, 99);
      if (pick < 20) r.feat = FEAT_ENABLE;
      else if (pick < 30) r.feat = FEAT_POWER;
      else if (pick < 60) r.feat = FEAT_C_CONNECTION;
      else if (pick < 90) r.feat = FEAT_C_RESET;
    end else if (pick < 88) begin
      r.op = OP_CHANGE_POLL;
    end else if (pick < 94) begin
      r.op = OP_HUB_STATUS;
    end else begin
      r.op = ($urandom_range(0, 1) != 0) ? OP_OTHER : OP_RESERVED;
    end
    return r;
  endfunction

  task automatic send_request(input port_req_t r, input logic use_typed, input result_t typed);
    result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0, r.present, r.port, r.feat, r.op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = port_step(r);
    pending_results.push_back(use_typed ? typed : predicted);
    @(negedge clk_i);
  endtask

  // only while idle: every result drained, nothing offered
  task automatic write_reset_ticks(input logic [15:0] ticks);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = ticks;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    mdl_reset_ticks = ticks;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready_i = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[40:0];
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding: %h", got);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.status_word !== want.status_word) begin
          $error("status_word: expected %h, got %h", want.status_word, got.status_word);
          mismatch_cnt++;
        end
        if (got.port_change !== want.port_change) begin
          $error("port_change: expected %h, got %h", want.port_change, got.port_change);
          mismatch_cnt++;
        end
        if (got.change_bitmap !== want.change_bitmap) begin
          $error("change_bitmap: expected %h, got %h", want.change_bitmap, got.change_bitmap);
          mismatch_cnt++;
        end
        if (got.request_error !== want.request_error) begin
          $error("request_error: expected %b, got %b", want.request_error, got.request_error);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] phase_ticks[4];
    result_t     typed;
    port_req_t   r;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    mismatch_cnt    = 0;
    quiet_cycles    = 0;
    link_up         = 1'b1;
    mdl_status      = '0;
    mdl_change      = '0;
    mdl_countdown   = '0;
    mdl_reset_ticks = RESET_TICKS_DEFAULT;
    src_idle_pct    = 10;
    sink_idle_pct   = 54;

    // reset_ticks is 2 for this part; C = connection, E = enable, R = reset, P = power
    dir_tab = '{
      '{'{OP_GET_STATUS, 16'h0000, 16'h0001, 1'b0}, 1'b1, 16'h0000, 16'h0000, 8'd0, 1'b0},
      '{'{OP_GET_STATUS, 16'h0000, 16'hFFFF, 1'b1}, 1'b1, 16'h0000, 16'h0000, 8'd0, 1'b1},
      // reset on a port that is not connected (still unpowered) is dropped silently
      '{'{OP_SET_FEATURE, FEAT_RESET, 16'h0001, 1'b1}, 1'b1, 16'h0000, 16'h0000, 8'd0, 1'b0},
      '{'{OP_SET_FEATURE, FEAT_POWER, 16'h0001, 1'b0}, 1'b1, 16'h0100, 16'h0000, 8'd0, 1'b0},
      '{'{OP_SET_FEATURE, FEAT_POWER, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0001, 8'd2, 1'b0},
      '{'{OP_CLEAR_FEATURE, FEAT_C_CONNECTION, 16'h0001, 1'b1}, 1'b1,
        16'h0101, 16'h0000, 8'd0, 1'b0},
      '{'{OP_SET_FEATURE, FEAT_RESET, 16'h0001, 1'b1}, 1'b1, 16'h0111, 16'h0000, 8'd0, 1'b0},
      '{'{OP_GET_STATUS, 16'h0000, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      '{'{OP_TICK, 16'h0000, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      // second reset restarts the countdown
      '{'{OP_SET_FEATURE, FEAT_RESET, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      '{'{OP_TICK, 16'h0000, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      '{'{OP_GET_STATUS, 16'h0000, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      '{'{OP_TICK, 16'h0000, 16'h0001, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      '{'{OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, 16'h0, 16'h0, 8'd0, 1'b0},
      // wrong port stalls but still completes the reset
      '{'{OP_GET_STATUS, 16'h0000, 16'h0000, 1'b1}, 1'b1, 16'h0101, 16'h0010, 8'd2, 1'b1},
      '{'{OP_CHANGE_POLL, 16'h0000, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0010, 8'd2, 1'b0},
      '{'{OP_HUB_STATUS, 16'h0000, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0010, 8'd2, 1'b0},
      '{'{OP_CLEAR_FEATURE, FEAT_C_RESET, 16'hFFFF, 1'b1}, 1'b1,
        16'h0101, 16'h0000, 8'd0, 1'b0},
      '{'{OP_CLEAR_FEATURE, FEAT_ENABLE, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0000, 8'd0, 1'b0},
      '{'{OP_SET_FEATURE, 16'hFFFF, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0000, 8'd0, 1'b1},
      '{'{OP_CLEAR_FEATURE, 16'h0000, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0000, 8'd0, 1'b1},
      '{'{OP_OTHER, 16'h0000, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0000, 8'd0, 1'b1},
      '{'{OP_RESERVED, 16'hFFFF, 16'h0001, 1'b1}, 1'b1, 16'h0101, 16'h0000, 8'd0, 1'b1},
      '{'{OP_GET_STATUS, 16'h0000, 16'h0001, 1'b0}, 1'b1, 16'h0100, 16'h0001, 8'd2, 1'b0},
      '{'{OP_CLEAR_FEATURE, FEAT_POWER, 16'h0001, 1'b0}, 1'b1, 16'h0000, 16'h0000, 8'd0, 1'b0}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reset_ticks(16'd2);
    foreach (dir_tab[i]) begin
      typed.status_word   = dir_tab[i].st;
      typed.port_change   = dir_tab[i].ch;
      typed.change_bitmap = dir_tab[i].map;
      typed.request_error = dir_tab[i].err;
      send_request(dir_tab[i].req, dir_tab[i].typed, typed);
    end

    phase_ticks[0] = 16'd1;
    phase_ticks[1] = 16'd0;
    phase_ticks[2] = 16'hFFFF;
    phase_ticks[3] = 16'($urandom_range(3, 20));
    for (int ph = 0; ph < 4; ph++) begin
      write_reset_ticks(phase_ticks[ph]);
      src_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 54 : 0;
      sink_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 10 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        r = random_request();
        send_request(r, 1'b0, typed);
      end
    end

    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/urhp_pkg.sv
sv/usb_root_hub_port_top.sv
tb/tb_usb_root_hub_port_top.sv
